// ===== rtl/cdgm_pkg.sv =====
// Shared constants and types for the central difference gradient magnitude block.
package cdgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int FRAC_BITS  = 4;
  localparam int HEIGHT_MAX = 4095;

  localparam int PIX_W     = 8;
  localparam int MAG_W     = 12;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // line store address / column counter width
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // width used to compare the column against the effective frame width
  localparam int WW = (FW_W > AW + 1) ? FW_W : AW + 1;

  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

  // magnitude datapath: 4^F/4 * (dx^2 + dy^2), then integer square root
  localparam int SQ_W    = 2 * PIX_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int RAD_W   = (FRAC_BITS >= 1) ? SUM_W + 2 * FRAC_BITS - 2 : SUM_W - 2;
  localparam int RAD_SHL = (FRAC_BITS >= 1) ? 2 * FRAC_BITS - 2 : 0;
  localparam int ROOT_W  = (RAD_W + 1) / 2;
  localparam int RAD2_W  = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  // horizontal-only magnitude is an exact scale of |dx|
  localparam int BX_SHL  = (FRAC_BITS >= 1) ? FRAC_BITS - 1 : 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // first pipeline stage: raw pixels plus decoded position flags
  typedef struct packed {
    logic             sel;        // store A holds the previous row
    logic             first_sel;  // row end: next window value is pixel 0 of this row
    logic [PIX_W-1:0] first_px;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] prev2;      // pixel two columns back in the current row
    logic             dxa_ok;
    logic             dya_ok;
    logic             dxb_ok;
    logic             has_a;
    logic             has_b;
    logic             has_c;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [AW-1:0]    col;
  } s1_t;

  // sideband carried alongside the magnitude datapath
  typedef struct packed {
    logic             has_a;
    logic             has_b;
    logic             has_c;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [AW-1:0]    col;
    logic [PIX_W-1:0] bx;
  } meta_t;

endpackage

// ===== rtl/cdgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read-first: a same-address write returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/central_difference_gradient_magnitude_top.sv =====
// Path: an accepted pixel passes the front stages, the square-root stages and the output register.
// Throughput: one pixel per cycle while the output accepts; on the last row a pixel yields
// up to 3 results, handed out one per cycle as accepted, and the pipeline stalls behind them.
// Pipeline depth is set by the bit-per-stage square root (12 stages) plus 4 front stages.
// Reset: counters to zero, width/height to 640/480; line stores are not cleared.
module central_difference_gradient_magnitude_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cdgm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cdgm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cdgm_pkg::PIX_W-1:0]     pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cdgm_pkg::MAG_W-1:0]     magnitude_o,
  output logic [cdgm_pkg::ROW_W-1:0]     row_o,
  output logic [cdgm_pkg::COL_W-1:0]     col_o,
  output logic                           end_of_run_o,
  output logic                           end_of_frame_o
);
  import cdgm_pkg::*;

  function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    absdiff = (a >= b) ? a - b : b - a;
  endfunction

  // configuration and position
  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [ROW_W-1:0] row_q;
  logic [AW-1:0]    col_q;
  logic             a_is_newer_q;
  logic [WW-1:0]    w_eff, w_last;
  logic [FH_W-1:0]  h_eff, h_last;
  logic             row_end, last_row, frame_end;
  logic             en, in_fire;

  logic [PIX_W-1:0] cur0_q, cur1_q, first_px_q;

  // line stores
  logic [AW-1:0]    addr_next, raddr_a, raddr_b;
  logic             we_a, we_b;
  logic [PIX_W-1:0] rdata_a, rdata_b;

  // pipeline
  logic             s1_v_q, s2_v_q, s3_v_q;
  s1_t              s1_d, s1_q;
  logic [PIX_W-1:0] win0_q, win1_q, older_px, newer_px, next_px;
  logic [PIX_W-1:0] s2_ax_q, s2_ay_q;
  meta_t            s2_meta_d, s2_meta_q, s3_meta_q;
  logic [SQ_W-1:0]  s3_sx_q, s3_sy_q;
  logic [SUM_W-1:0] sum;
  logic [SUM_W+14:0] sum_ext;
  logic [RAD2_W-1:0] rad_d;

  logic [ROOT_W:0]   sq_v_q;
  logic [REM_W-1:0]  sq_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_q [ROOT_W+1];
  logic [RAD2_W-1:0] sq_rad_q  [ROOT_W+1];
  meta_t             sq_meta_q [ROOT_W+1];

  // output register
  logic [2:0]       ob_mask_q;
  logic [MAG_W-1:0] ob_mag_a_q, ob_mag_b_q, mag_b;
  logic [PIX_W+7:0] bx_ext;
  logic [ROW_W-1:0] ob_row_q, ob_row_m1_q;
  logic [COL_W-1:0] ob_col_q, ob_col_m1_q;
  logic             ob_fe_q;
  logic             ob_single, buf_ok, ob_load, out_fire;
  meta_t            tail_meta;

  // ---------------------------------------------------------------- front end
  always_comb begin
    if (WW'(frame_width_q) < WW'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(frame_width_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end
    if (frame_height_q < FH_W'(3)) begin
      h_eff = FH_W'(3);
    end else if (frame_height_q > FH_W'(HEIGHT_MAX)) begin
      h_eff = FH_W'(HEIGHT_MAX);
    end else begin
      h_eff = frame_height_q;
    end
    w_last    = w_eff - WW'(1);
    h_last    = h_eff - FH_W'(1);
    row_end   = WW'(col_q) >= w_last;
    last_row  = ROW_W'(row_q) >= ROW_W'(h_last);
    frame_end = row_end && last_row;
  end

  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      row_q          <= '0;
      col_q          <= '0;
      a_is_newer_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FH_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (row_end) begin
          col_q        <= '0;
          row_q        <= frame_end ? '0 : row_q + ROW_W'(1);
          a_is_newer_q <= !a_is_newer_q;
        end else begin
          col_q <= col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur1_q <= cur0_q;
      cur0_q <= pixel_i;
      if (col_q == '0) begin
        first_px_q <= pixel_i;
      end
    end
  end

  // the store holding the row before last is written in place, after its read
  assign addr_next = col_q + AW'(1);
  assign raddr_a   = a_is_newer_q ? addr_next : col_q;
  assign raddr_b   = a_is_newer_q ? col_q : addr_next;
  assign we_a      = in_fire && !a_is_newer_q;
  assign we_b      = in_fire && a_is_newer_q;

  cdgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (col_q),
    .wdata_i (pixel_i),
    .re_i    (en),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  cdgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (col_q),
    .wdata_i (pixel_i),
    .re_i    (en),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  always_comb begin
    s1_d.sel       = a_is_newer_q;
    s1_d.first_sel = row_end;
    s1_d.first_px  = first_px_q;
    s1_d.px        = pixel_i;
    s1_d.prev2     = cur1_q;
    s1_d.dxa_ok    = (col_q != '0) && !row_end;
    s1_d.dya_ok    = (row_q >= ROW_W'(2)) && (row_q < ROW_W'(h_eff));
    s1_d.dxb_ok    = col_q >= AW'(2);
    s1_d.has_a     = row_q != '0;
    s1_d.has_b     = last_row && (col_q != '0);
    s1_d.has_c     = last_row && row_end;
    s1_d.frame_end = frame_end;
    s1_d.row       = row_q;
    s1_d.col       = col_q;
  end

  // ---------------------------------------------------------------- differences
  // window holds previous-row pixels c and c-1; the RAM word is pixel c+1
  always_comb begin
    older_px = s1_q.sel ? rdata_b : rdata_a;
    newer_px = s1_q.sel ? rdata_a : rdata_b;
    next_px  = s1_q.first_sel ? s1_q.first_px : newer_px;
    s2_meta_d.has_a     = s1_q.has_a;
    s2_meta_d.has_b     = s1_q.has_b;
    s2_meta_d.has_c     = s1_q.has_c;
    s2_meta_d.frame_end = s1_q.frame_end;
    s2_meta_d.row       = s1_q.row;
    s2_meta_d.col       = s1_q.col;
    s2_meta_d.bx        = s1_q.dxb_ok ? absdiff(s1_q.px, s1_q.prev2) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      s2_ax_q   <= s1_q.dxa_ok ? absdiff(next_px, win1_q) : '0;
      s2_ay_q   <= s1_q.dya_ok ? absdiff(s1_q.px, older_px) : '0;
      s2_meta_q <= s2_meta_d;
      if (s1_v_q) begin
        win1_q <= win0_q;
        win0_q <= next_px;
      end
      s3_sx_q   <= s2_ax_q * s2_ax_q;
      s3_sy_q   <= s2_ay_q * s2_ay_q;
      s3_meta_q <= s2_meta_q;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_rad_q[0]  <= rad_d;
      sq_meta_q[0] <= s3_meta_q;
    end
  end

  always_comb begin
    sum     = SUM_W'(s3_sx_q) + SUM_W'(s3_sy_q);
    sum_ext = (SUM_W + 15)'(sum);
    if (FRAC_BITS >= 1) begin
      rad_d = RAD2_W'(sum_ext << RAD_SHL);
    end else begin
      rad_d = RAD2_W'(sum_ext >> 2);
    end
  end

  // ---------------------------------------------------------------- square root
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [REM_W+1:0]  cand, trial;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    always_comb begin
      cand  = {sq_rem_q[j], sq_rad_q[j][2*(ROOT_W-1-j) +: 2]};
      trial = (REM_W + 2)'({sq_root_q[j], 2'b01});
      if (cand >= trial) begin
        rem_d  = REM_W'(cand - trial);
        root_d = {sq_root_q[j][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(cand);
        root_d = {sq_root_q[j][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[j+1]  <= rem_d;
        sq_root_q[j+1] <= root_d;
        sq_rad_q[j+1]  <= sq_rad_q[j];
        sq_meta_q[j+1] <= sq_meta_q[j];
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign tail_meta = sq_meta_q[ROOT_W];
  assign ob_single = (ob_mask_q != 3'b000) && ((ob_mask_q & (ob_mask_q - 3'd1)) == 3'b000);
  assign buf_ok    = (ob_mask_q == 3'b000) || (ob_single && out_ready_i);
  assign en        = !sq_v_q[ROOT_W] || buf_ok;
  assign ob_load   = sq_v_q[ROOT_W] && buf_ok;
  assign out_fire  = out_valid_o && out_ready_i;

  always_comb begin
    bx_ext = (PIX_W + 8)'(tail_meta.bx);
    if (FRAC_BITS >= 1) begin
      mag_b = MAG_W'(bx_ext << BX_SHL);
    end else begin
      mag_b = MAG_W'(bx_ext >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      sq_v_q    <= '0;
      ob_mask_q <= 3'b000;
    end else begin
      if (en) begin
        s1_v_q <= in_fire;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
        sq_v_q <= {sq_v_q[ROOT_W-1:0], s3_v_q};
      end
      if (ob_load) begin
        ob_mask_q <= {tail_meta.has_c, tail_meta.has_b, tail_meta.has_a};
      end else if (out_fire) begin
        ob_mask_q <= ob_mask_q & (ob_mask_q - 3'd1);  // drop lowest pending result
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_load) begin
      ob_mag_a_q  <= MAG_W'(sq_root_q[ROOT_W]);
      ob_mag_b_q  <= mag_b;
      ob_row_q    <= tail_meta.row;
      ob_row_m1_q <= tail_meta.row - ROW_W'(1);
      ob_col_q    <= COL_W'(tail_meta.col);
      ob_col_m1_q <= COL_W'(tail_meta.col - AW'(1));
      ob_fe_q     <= tail_meta.frame_end;
    end
  end

  // order per pixel: the pixel above, then the left neighbour, then itself
  always_comb begin
    out_valid_o    = ob_mask_q != 3'b000;
    end_of_run_o   = ob_single;
    end_of_frame_o = ob_single && ob_fe_q;
    if (ob_mask_q[0]) begin
      magnitude_o = ob_mag_a_q;
      row_o       = ob_row_m1_q;
      col_o       = ob_col_q;
    end else if (ob_mask_q[1]) begin
      magnitude_o = ob_mag_b_q;
      row_o       = ob_row_q;
      col_o       = ob_col_m1_q;
    end else begin
      magnitude_o = '0;
      row_o       = ob_row_q;
      col_o       = ob_col_q;
    end
  end

  // ---------------------------------------------------------------- checks
  a_eof_is_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_frame_o) |-> end_of_run_o)
    else $error("end_of_frame without end_of_run");

  a_ready_low_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (sq_v_q[ROOT_W] && out_valid_o))
    else $error("input stalled without a pending result");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sq_v_q) && $stable(s1_v_q) && $stable(s2_v_q) && $stable(s3_v_q)))
    else $error("pipeline moved during stall");

  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && row_end) |=> (a_is_newer_q != $past(a_is_newer_q)))
    else $error("line stores did not swap at row end");

endmodule
